/* rtl/table_driven_dfa_acceptor_unit_macros.svh */
// Assertion macros shared by the DFA acceptor RTL.
`ifndef TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_MACROS_SVH
`define TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TDFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdfa assertion failed");
// Next-cycle implication, checked outside reset.
`define TDFA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdfa assertion failed");
`else
`define TDFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define TDFA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/tdfa_pkg.sv */
// Shared constants, codes and types of the DFA acceptor.
package tdfa_pkg;

  localparam int STATE_COUNT  = 16;
  localparam int SYMBOL_COUNT = 16;
  localparam int STATE_W      = $clog2(STATE_COUNT);
  localparam int SLOT_W       = $clog2(SYMBOL_COUNT);
  localparam int CHAR_W       = 8;
  localparam int OPCODE_W     = 3;
  localparam int SYM_COUNT_W  = 5;
  localparam int TRANS_DEPTH  = STATE_COUNT * SYMBOL_COUNT;
  localparam int TRANS_AW     = STATE_W + SLOT_W;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_SYMBOL = 3'd0,
    OP_SET_TRANS  = 3'd1,
    OP_SET_ACCEPT = 3'd2,
    OP_CHAR       = 3'd3,
    OP_END        = 3'd4
  } opcode_t;

  typedef enum logic [0:0] {
    REG_SYMBOL_COUNT  = 1'b0,
    REG_INITIAL_STATE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SYM_COUNT_W-1:0] symbol_count;
    logic [STATE_W-1:0]     initial_state;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_t;

endpackage

/* rtl/tdfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tdfa_cfg.sv */
// APB register block: symbol_count and initial_state.
module tdfa_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdfa_pkg::CFG_AW-1:0] paddr,
  input  logic [tdfa_pkg::CFG_DW-1:0] pwdata,
  output logic [tdfa_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output tdfa_pkg::cfg_t              cfg
);
  import tdfa_pkg::*;

  reg_index_t reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_count  <= '0;
      cfg.initial_state <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SYMBOL_COUNT:  cfg.symbol_count  <= pwdata[SYM_COUNT_W-1:0];
        REG_INITIAL_STATE: cfg.initial_state <= pwdata[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYMBOL_COUNT:  prdata = CFG_DW'(cfg.symbol_count);
      REG_INITIAL_STATE: prdata = CFG_DW'(cfg.initial_state);
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/tdfa_match.sv */
// Alphabet store and parallel lowest-slot character match.
module tdfa_match (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [tdfa_pkg::SLOT_W-1:0]      wr_slot,
  input  logic [tdfa_pkg::CHAR_W-1:0]      wr_char,
  input  logic [tdfa_pkg::SYM_COUNT_W-1:0] symbol_count,
  input  logic [tdfa_pkg::CHAR_W-1:0]      char_code,
  output tdfa_pkg::match_t                 match
);
  import tdfa_pkg::*;

  logic [CHAR_W-1:0] symbols [SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      symbols[wr_slot] <= wr_char;
    end
  end

  // Scan from the top slot down so the lowest hit wins.
  always_comb begin
    match.hit  = 1'b0;
    match.slot = '0;
    for (int i = SYMBOL_COUNT - 1; i >= 0; i--) begin
      if ((SYM_COUNT_W'(i) < symbol_count) && (symbols[i] == char_code)) begin
        match.hit  = 1'b1;
        match.slot = SLOT_W'(i);
      end
    end
  end

endmodule

/* rtl/table_driven_dfa_acceptor_unit.sv */
// Throughput: one item per cycle of any kind, but an end item stalls on a full
// result register; its verdict goes via the input and result registers.
// The state loop runs through the transition RAM's registered read port,
// which feeds the next character's lookup address directly.
// Reset (synchronous): clears control state, registers and accept map; the alphabet
// and transition table are undefined until loaded; no clearing pass.
module table_driven_dfa_acceptor_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] char_code, [11:8] symbol_slot, [15:12] from_state,
  // [19:16] target_state, [20] accept_bit, [23:21] zero
  input  logic [tdfa_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [2:0] opcode
  input  logic [tdfa_pkg::OPCODE_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] accepted, [1] bad_symbol, [7:2] zero
  output logic [tdfa_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tdfa_pkg::CFG_AW-1:0]      paddr,
  input  logic [tdfa_pkg::CFG_DW-1:0]      pwdata,
  output logic [tdfa_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready
);
  import tdfa_pkg::*;
`include "table_driven_dfa_acceptor_unit_macros.svh"

  cfg_t   cfg;
  match_t match;

  // input register
  logic              in_valid;
  opcode_t           in_op;
  logic [CHAR_W-1:0] in_char;
  logic [SLOT_W-1:0] in_slot;
  logic [STATE_W-1:0] in_from;
  logic [STATE_W-1:0] in_target;
  logic              in_abit;

  // string state
  logic [STATE_W-1:0] state_reg;
  logic              trans_pend;
  logic              in_string;
  logic              rejected;
  logic [STATE_COUNT-1:0] accept_map;

  // result register
  logic out_accepted;
  logic out_bad;

  logic               out_free;
  logic               fire;
  logic               is_char;
  logic               is_end;
  logic               char_step;
  logic               rd_go;
  logic               rej_eff;
  logic [STATE_W-1:0] ram_rdata;
  logic [STATE_W-1:0] cur_state;
  logic [STATE_W-1:0] base_state;

  tdfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdfa_match u_match (
    .clk          (clk),
    .wr_en        (fire && (in_op == OP_SET_SYMBOL)),
    .wr_slot      (in_slot),
    .wr_char      (in_char),
    .symbol_count (cfg.symbol_count),
    .char_code    (in_char),
    .match        (match)
  );

  tdfa_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TRANS_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (fire && (in_op == OP_SET_TRANS)),
    .waddr ({in_from, in_slot}),
    .wdata (in_target),
    .raddr ({base_state, match.slot}),
    .rdata (ram_rdata)
  );

  assign is_char  = (in_op == OP_CHAR);
  assign is_end   = (in_op == OP_END);
  assign out_free = !m_tvalid || m_tready;
  // only an end item needs room in the result register
  assign fire     = in_valid && (!is_end || out_free);
  assign s_tready = !in_valid || fire;

  // the transition read lands in the cycle after its character
  assign cur_state  = trans_pend ? ram_rdata : state_reg;
  assign base_state = in_string ? cur_state : cfg.initial_state;
  assign rej_eff    = in_string && rejected;
  assign char_step  = fire && is_char && !rej_eff;
  assign rd_go      = char_step && match.hit;

  assign m_tdata = {(OUT_TDATA_W - 2)'(0), out_bad, out_accepted};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= opcode_t'(s_tuser);
      in_char   <= s_tdata[7:0];
      in_slot   <= s_tdata[11:8];
      in_from   <= s_tdata[15:12];
      in_target <= s_tdata[19:16];
      in_abit   <= s_tdata[20];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_reg  <= '0;
      trans_pend <= 1'b0;
      in_string  <= 1'b0;
      rejected   <= 1'b0;
      accept_map <= '0;
    end else begin
      state_reg  <= (fire && (is_char || is_end)) ? base_state : cur_state;
      trans_pend <= rd_go;
      if (fire && is_char) begin
        in_string <= 1'b1;
      end else if (fire && is_end) begin
        in_string <= 1'b0;
      end
      if (fire && is_end) begin
        rejected <= 1'b0;
      end else if (char_step && !match.hit) begin
        rejected <= 1'b1;
      end
      if (fire && (in_op == OP_SET_ACCEPT)) begin
        accept_map[in_from] <= in_abit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_end) begin
      out_accepted <= !rej_eff && accept_map[base_state];
      out_bad      <= rej_eff;
    end
  end

  `TDFA_ASSERT_IMP(a_verdict_excl, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[1]))
  `TDFA_ASSERT_IMP(a_reject_in_string, clk, rst, rejected, in_string)
  `TDFA_ASSERT_IMP(a_pend_in_string, clk, rst, trans_pend, in_string)
  `TDFA_ASSERT_NXT(a_end_rearms, clk, rst, fire && is_end, m_tvalid && !in_string)
  `TDFA_ASSERT_IMP(a_end_stall, clk, rst, in_valid && is_end && !out_free, !s_tready)

endmodule

/* verif/table_driven_dfa_acceptor_unit_test.sv */
// Self-checking testbench for the table-driven DFA acceptor: directed and random strings.
`timescale 1ns / 100ps

module table_driven_dfa_acceptor_unit_test;
  import tdfa_pkg::*;

  localparam realtime CLK_PERIOD    = 10.0;
  localparam int      RESET_CYCLES  = 8;
  localparam int      SETTLE_CYCLES = 4;
  localparam int      CYCLE_LIMIT   = 400000;
  localparam int      RANDOM_ITEMS  = 1280;
  localparam int      PHASES        = 8;
  localparam int      MAX_PRINTED   = 40;

  localparam logic [OPCODE_W-1:0] FIRST_UNUSED_OP = OPCODE_W'(OP_END + 1);
  localparam logic [OPCODE_W-1:0] LAST_OPCODE     = '1;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [CHAR_W-1:0]   char_code;
    logic [SLOT_W-1:0]   symbol_slot;
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  target_state;
    logic                accept_bit;
  } dfa_item_t;

  typedef struct packed {
    logic accepted;
    logic bad_symbol;
  } verdict_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // [7:0] char_code, [11:8] symbol_slot, [15:12] from_state,
  // [19:16] target_state, [20] accept_bit, [23:21] zero
  logic [IN_TDATA_W-1:0]  s_tdata;
  // [2:0] opcode
  logic [OPCODE_W-1:0]    s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  // [0] accepted, [1] bad_symbol, [7:2] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_AW-1:0]      paddr;
  logic [CFG_DW-1:0]      pwdata;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  // Shadow copy of the acceptor: configuration, stores and string state.
  logic [SYM_COUNT_W-1:0] cfg_symbol_count;
  logic [STATE_W-1:0]     cfg_initial_state;
  logic [CHAR_W-1:0]      alphabet [SYMBOL_COUNT];
  logic [STATE_W-1:0]     next_state_tab [STATE_COUNT][SYMBOL_COUNT];
  logic                   accepting [STATE_COUNT];
  logic [STATE_W-1:0]     dfa_state;
  logic                   dfa_in_string;
  logic                   dfa_rejected;

  verdict_t verdict_q [$];
  verdict_t want;
  int       error_count;
  int       cycle_count;
  bit       src_steady;
  bit       sink_steady;
  int       sink_hold;

  table_driven_dfa_acceptor_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void open_string();
    if (!dfa_in_string) begin
      dfa_state     = cfg_initial_state;
      dfa_in_string = 1'b1;
      dfa_rejected  = 1'b0;
    end
  endfunction

  // Advance the shadow DFA by one item; an end item queues its verdict.
  function automatic void track_dfa(input dfa_item_t it);
    int n;
    int hit_slot;
    int i;
    hit_slot = -1;
    case (it.op)
      OP_SET_SYMBOL: alphabet[it.symbol_slot] = it.char_code;
      OP_SET_TRANS:  next_state_tab[it.from_state][it.symbol_slot] = it.target_state;
      OP_SET_ACCEPT: accepting[it.from_state] = it.accept_bit;
      OP_CHAR: begin
        open_string();
        if (!dfa_rejected) begin
          n = (cfg_symbol_count > SYMBOL_COUNT) ? SYMBOL_COUNT : int'(cfg_symbol_count);
          for (i = 0; i < n; i++)
            if (hit_slot < 0 && alphabet[i] == it.char_code) hit_slot = i;
          if (hit_slot < 0) dfa_rejected = 1'b1;
          else dfa_state = next_state_tab[dfa_state][hit_slot];
        end
      end
      OP_END: begin
        open_string();
        verdict_q.push_back(verdict_t'{accepted: !dfa_rejected && accepting[dfa_state],
                                       bad_symbol: dfa_rejected});
        dfa_in_string = 1'b0;
        dfa_rejected  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [SLOT_W-1:0] slot, input logic [STATE_W-1:0] from,
                           input logic [STATE_W-1:0] target, input logic abit);
    dfa_item_t it;
    int gap;
    it = '{op: op, char_code: ch, symbol_slot: slot, from_state: from,
           target_state: target, accept_bit: abit};
    if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, abit, target, from, slot, ch};
    do @(posedge clk); while (!s_tready);
    track_dfa(it);
  endtask

  task automatic send_random(input logic [OPCODE_W-1:0] op);
    send_item(op, CHAR_W'($urandom_range(0, 255)), SLOT_W'($urandom_range(0, 15)),
              STATE_W'($urandom_range(0, 15)), STATE_W'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every verdict is in and the pipe is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYMBOL_COUNT:  cfg_symbol_count  = value[SYM_COUNT_W-1:0];
      REG_INITIAL_STATE: cfg_initial_state = value[STATE_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: random stalls, compare each verdict with the oldest one queued.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %b with none expected", m_tdata[1:0]));
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b", m_tdata[0], want.accepted));
          if (m_tdata[1] !== want.bad_symbol)
            report_mismatch($sformatf("bad_symbol %b, expected %b",
                                      m_tdata[1], want.bad_symbol));
        end
        if ($urandom_range(0, 24) == 0) sink_steady = !sink_steady;
        sink_hold = sink_steady ? 0 : $urandom_range(0, 9);
      end
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Empty string, an unused opcode and characters with an empty alphabet, straight out of reset.
  task automatic test_after_reset();
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_CHAR, 8'hFF, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_CHAR, 8'h00, 4'hF, 4'hF, 4'hF, 1'b1);
    send_item(LAST_OPCODE, 8'hFF, 4'hF, 4'hF, 4'hF, 1'b1);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
  endtask

  // Fill the alphabet with distinct bytes and write every transition and accept flag.
  task automatic test_table_load();
    int s;
    int c;
    for (c = 0; c < SYMBOL_COUNT; c++)
      send_item(OP_SET_SYMBOL, 8'(c * 17), 4'(c), STATE_W'($urandom_range(0, 15)),
                STATE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    for (s = 0; s < STATE_COUNT; s++)
      for (c = 0; c < SYMBOL_COUNT; c++)
        send_item(OP_SET_TRANS, CHAR_W'($urandom_range(0, 255)), 4'(c), 4'(s),
                  STATE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    for (s = 0; s < STATE_COUNT; s++)
      send_item(OP_SET_ACCEPT, CHAR_W'($urandom_range(0, 255)),
                SLOT_W'($urandom_range(0, 15)), 4'(s),
                STATE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    settle();
  endtask

  task automatic test_directed_strings();
    write_reg(REG_SYMBOL_COUNT, 32'd16);
    write_reg(REG_INITIAL_STATE, 32'd15);
    // empty string from an accepting start state
    send_item(OP_SET_ACCEPT, 8'h00, 4'h0, 4'hF, 4'h0, 1'b1);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    // same byte in slots 1 and 3: slot 1 must win
    send_item(OP_SET_SYMBOL, 8'h11, 4'h3, 4'h0, 4'h0, 1'b0);
    send_item(OP_SET_TRANS, 8'h00, 4'h1, 4'hF, 4'h0, 1'b0);
    send_item(OP_SET_TRANS, 8'h00, 4'h3, 4'hF, 4'hF, 1'b0);
    send_item(OP_SET_ACCEPT, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_CHAR, 8'h11, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    // unknown byte latches a reject; later characters are ignored
    send_item(OP_CHAR, 8'h12, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    // alphabet load in mid-string is used at once
    send_item(OP_CHAR, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_SET_SYMBOL, 8'hAB, 4'h2, 4'h0, 4'h0, 1'b0);
    send_item(OP_CHAR, 8'hAB, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    settle();
    // symbol count above the alphabet size saturates
    write_reg(REG_SYMBOL_COUNT, '1);
    send_item(OP_CHAR, 8'hFF, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    settle();
    // one slot in use: the top byte no longer matches
    write_reg(REG_SYMBOL_COUNT, 32'd1);
    write_reg(REG_INITIAL_STATE, 32'd0);
    send_item(OP_CHAR, 8'hFF, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_END, 8'h00, 4'h0, 4'h0, 4'h0, 1'b0);
    settle();
  endtask

  // Mostly well-formed strings over the live alphabet, with loads and noise mixed in.
  task automatic test_random_strings();
    int phase;
    int sent;
    int len;
    int k;
    int pick;
    int n_live;
    logic [CFG_DW-1:0] count_val;
    logic [CFG_DW-1:0] init_val;
    for (phase = 0; phase < PHASES; phase++) begin
      count_val = (phase == 0) ? 32'd16 : (phase == 1) ? 32'd0 :
                  (phase == 2) ? 32'hFFFF_FFFF : (phase == 3) ? 32'd1 :
                  $urandom_range(2, 31);
      init_val  = (phase == 0) ? 32'd0 : (phase == 1) ? 32'd15 : $urandom;
      write_reg(REG_SYMBOL_COUNT, count_val);
      write_reg(REG_INITIAL_STATE, init_val);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        len = $urandom_range(0, 8);
        for (k = 0; k < len; k++) begin
          pick   = $urandom_range(0, 99);
          n_live = (cfg_symbol_count > SYMBOL_COUNT) ? SYMBOL_COUNT : int'(cfg_symbol_count);
          if (pick < 6) begin
            send_random(opcode_t'($urandom_range(OP_SET_SYMBOL, OP_SET_ACCEPT)));
            sent++;
          end else if (pick < 8) begin
            send_random(OPCODE_W'($urandom_range(FIRST_UNUSED_OP, LAST_OPCODE)));
          end else if (pick < 92 && n_live > 0) begin
            send_item(OP_CHAR, alphabet[$urandom_range(0, n_live - 1)],
                      SLOT_W'($urandom_range(0, 15)), STATE_W'($urandom_range(0, 15)),
                      STATE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            sent++;
          end else begin
            send_random(OP_CHAR);
            sent++;
          end
        end
        send_random(OP_END);
        sent++;
      end
      settle();
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    m_tready  = 1'b0;
    error_count = 0;
    cycle_count = 0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    sink_hold   = 0;
    cfg_symbol_count  = '0;
    cfg_initial_state = '0;
    dfa_state     = '0;
    dfa_in_string = 1'b0;
    dfa_rejected  = 1'b0;
    foreach (accepting[s]) accepting[s] = 1'b0;
    foreach (alphabet[c]) alphabet[c] = '0;
    foreach (next_state_tab[s, c]) next_state_tab[s][c] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    settle();
    test_table_load();
    test_directed_strings();
    test_random_strings();
    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tdfa_pkg.sv
rtl/tdfa_ram.sv
rtl/tdfa_cfg.sv
rtl/tdfa_match.sv
rtl/table_driven_dfa_acceptor_unit.sv
verif/table_driven_dfa_acceptor_unit_test.sv
